>>> rtl/core/uvf_pkg.sv
// Shared types and constants for the universal vertex finder.
// Used by uvf_row_mem, uvf_ctrl and universal_vertex_finder; depends on nothing.
`default_nettype none

package uvf_pkg;

  localparam int OP_W    = 3;
  localparam int OBJ_W   = 4;
  localparam int CNT_W   = 5;
  localparam int ENTRY_W = 2;

  localparam logic [OP_W-1:0] OP_RECORD   = 3'd0;
  localparam logic [OP_W-1:0] OP_TERMINAL = 3'd1;
  localparam logic [OP_W-1:0] OP_INITIAL  = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic STATUS_HIT  = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  localparam logic [ENTRY_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [ENTRY_W-1:0] CNT_MANY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_QRY,
    ST_TERM,
    ST_FIN,
    ST_INIT
  } uvf_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/uvf_row_mem.sv
// Row memory of the count matrix: one row of 2-bit counts per source object.
// Per-row valid bits stand in for clearing; depends on uvf_pkg.
`default_nettype none

module uvf_row_mem #(
  parameter int MAX_OBJECTS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  uvf_pkg::mem_ctl_t              ctl,
  input  wire  [$clog2(MAX_OBJECTS)-1:0] rd_addr,
  input  wire  [$clog2(MAX_OBJECTS)-1:0] wr_addr,
  input  wire  [2*MAX_OBJECTS-1:0]       wr_row,
  output logic [2*MAX_OBJECTS-1:0]       rd_row
);

  localparam int ROW_W = uvf_pkg::ENTRY_W * MAX_OBJECTS;

  logic [ROW_W-1:0]       mem [MAX_OBJECTS];
  logic [MAX_OBJECTS-1:0] row_valid;
  logic [ROW_W-1:0]       rd_data;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // A row never written since reset or the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

>>> rtl/core/uvf_ctrl.sv
// Sequencer for the vertex finder: record read-modify-write, pair query and
// row-by-row searches over the row memory. Depends on uvf_pkg.
`default_nettype none

module uvf_ctrl #(
  parameter int MAX_OBJECTS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  [uvf_pkg::CNT_W-1:0]        live_n,
  input  wire                              start,
  input  wire  [uvf_pkg::OP_W-1:0]         opcode,
  input  wire  [uvf_pkg::OBJ_W-1:0]        first_object,
  input  wire  [uvf_pkg::OBJ_W-1:0]        second_object,
  output logic                             busy,
  output logic                             done,
  output logic                             status,
  output logic [uvf_pkg::OBJ_W-1:0]        object_index,
  output uvf_pkg::mem_ctl_t                mem_ctl,
  output logic [$clog2(MAX_OBJECTS)-1:0]   rd_addr,
  output logic [$clog2(MAX_OBJECTS)-1:0]   wr_addr,
  output logic [2*MAX_OBJECTS-1:0]         wr_row,
  input  wire  [2*MAX_OBJECTS-1:0]         rd_row
);

  localparam int AW = $clog2(MAX_OBJECTS);

  uvf_pkg::uvf_state_t state, state_next;

  logic [uvf_pkg::OBJ_W-1:0] src, src_next;
  logic [uvf_pkg::OBJ_W-1:0] dst, dst_next;
  logic [uvf_pkg::CNT_W-1:0] scan, scan_next;
  logic [MAX_OBJECTS-1:0]    cand, cand_next;

  logic                      res_valid;
  logic                      res_status;
  logic [uvf_pkg::OBJ_W-1:0] res_index;

  logic                      accept;
  logic                      pair_in_range;
  logic                      last_row;
  logic [MAX_OBJECTS-1:0]    lane_live;
  logic [MAX_OBJECTS-1:0]    row_ones;
  logic                      row_all_one;
  logic [AW-1:0]             first_cand;
  logic [uvf_pkg::ENTRY_W-1:0] old_cnt;
  logic [uvf_pkg::ENTRY_W-1:0] new_cnt;

  assign accept        = start && !busy;
  assign busy          = (state != uvf_pkg::ST_IDLE);
  assign pair_in_range = ({1'b0, first_object} < live_n) && ({1'b0, second_object} < live_n);
  assign last_row      = (scan == live_n - uvf_pkg::CNT_W'(1));

  always_comb begin
    for (int c = 0; c < MAX_OBJECTS; c++) begin
      lane_live[c] = (c < int'(live_n));
      row_ones[c]  = (rd_row[2*c +: 2] == uvf_pkg::CNT_ONE);
    end
  end

  assign row_all_one = &(row_ones | ~lane_live);

  // Lowest surviving column; scan from the top so the lowest wins.
  always_comb begin
    first_cand = '0;
    for (int c = MAX_OBJECTS - 1; c >= 0; c--) begin
      if (cand[c]) begin
        first_cand = AW'(c);
      end
    end
  end

  assign old_cnt = rd_row[2*AW'(dst) +: 2];
  assign new_cnt = (old_cnt == uvf_pkg::CNT_MANY) ? old_cnt : old_cnt + 2'd1;

  always_comb begin
    wr_row = rd_row;
    wr_row[2*AW'(dst) +: 2] = new_cnt;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      uvf_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (opcode == uvf_pkg::OP_RECORD && pair_in_range) begin
            state_next = uvf_pkg::ST_REC;
          end else if (opcode == uvf_pkg::OP_QUERY && pair_in_range) begin
            state_next = uvf_pkg::ST_QRY;
          end else if (opcode == uvf_pkg::OP_TERMINAL && live_n != '0) begin
            state_next = uvf_pkg::ST_TERM;
          end else if (opcode == uvf_pkg::OP_INITIAL && live_n != '0) begin
            state_next = uvf_pkg::ST_INIT;
          end else begin
            state_next = uvf_pkg::ST_IDLE;
          end
        end
      end
      uvf_pkg::ST_REC:  state_next = uvf_pkg::ST_IDLE;
      uvf_pkg::ST_QRY:  state_next = uvf_pkg::ST_IDLE;
      uvf_pkg::ST_TERM: state_next = last_row ? uvf_pkg::ST_FIN : uvf_pkg::ST_TERM;
      uvf_pkg::ST_FIN:  state_next = uvf_pkg::ST_IDLE;
      uvf_pkg::ST_INIT: begin
        state_next = (row_all_one || last_row) ? uvf_pkg::ST_IDLE : uvf_pkg::ST_INIT;
      end
      default:          state_next = uvf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl    = '0;
    rd_addr    = '0;
    wr_addr    = AW'(src);
    src_next   = src;
    dst_next   = dst;
    scan_next  = scan;
    cand_next  = cand;
    res_valid  = 1'b0;
    res_status = uvf_pkg::STATUS_MISS;
    res_index  = '0;
    unique case (state)
      uvf_pkg::ST_IDLE: begin
        if (accept) begin
          src_next  = first_object;
          dst_next  = second_object;
          scan_next = '0;
          cand_next = lane_live;
          unique case (opcode)
            uvf_pkg::OP_RECORD: begin
              mem_ctl.rd_en = pair_in_range;
              rd_addr       = AW'(first_object);
            end
            uvf_pkg::OP_QUERY: begin
              mem_ctl.rd_en = pair_in_range;
              rd_addr       = AW'(first_object);
              res_valid     = !pair_in_range;
            end
            uvf_pkg::OP_TERMINAL, uvf_pkg::OP_INITIAL: begin
              mem_ctl.rd_en = (live_n != '0);
              res_valid     = (live_n == '0);
            end
            uvf_pkg::OP_CLEAR: begin
              mem_ctl.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      uvf_pkg::ST_REC: begin
        mem_ctl.wr_en = 1'b1;
      end
      uvf_pkg::ST_QRY: begin
        res_valid  = 1'b1;
        res_status = (old_cnt == uvf_pkg::CNT_ONE) ? uvf_pkg::STATUS_HIT
                                                   : uvf_pkg::STATUS_MISS;
      end
      uvf_pkg::ST_TERM: begin
        // Drop every column whose entry in this row is not exactly one.
        cand_next = cand & row_ones;
        if (!last_row) begin
          scan_next     = scan + uvf_pkg::CNT_W'(1);
          mem_ctl.rd_en = 1'b1;
          rd_addr       = AW'(scan + uvf_pkg::CNT_W'(1));
        end
      end
      uvf_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (cand != '0) begin
          res_status = uvf_pkg::STATUS_HIT;
          res_index  = uvf_pkg::OBJ_W'(first_cand);
        end
      end
      uvf_pkg::ST_INIT: begin
        if (row_all_one) begin
          res_valid  = 1'b1;
          res_status = uvf_pkg::STATUS_HIT;
          res_index  = uvf_pkg::OBJ_W'(scan);
        end else if (last_row) begin
          res_valid  = 1'b1;
        end else begin
          scan_next     = scan + uvf_pkg::CNT_W'(1);
          mem_ctl.rd_en = 1'b1;
          rd_addr       = AW'(scan + uvf_pkg::CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uvf_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    src          <= src_next;
    dst          <= dst_next;
    scan         <= scan_next;
    cand         <= cand_next;
    status       <= res_status;
    object_index <= res_index;
  end

  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.rd_en && (mem_ctl.wr_en || mem_ctl.clear)))
    else $error("row memory read overlaps a write or clear");

  a_fin_reports: assert property (@(posedge clk) disable iff (rst)
    state == uvf_pkg::ST_FIN |=> done)
    else $error("terminal search ended without a result");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == uvf_pkg::ST_TERM || state == uvf_pkg::ST_INIT) |-> scan < live_n)
    else $error("search row beyond the live object count");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && live_n != '0 &&
     (opcode == uvf_pkg::OP_TERMINAL || opcode == uvf_pkg::OP_INITIAL))
    |=> busy && !done)
    else $error("search accepted but not started");

endmodule

`default_nettype wire

>>> rtl/core/universal_vertex_finder.sv
// Top level of the universal vertex finder: object count register, sequencer
// and row memory. Depends on uvf_pkg, uvf_row_mem and uvf_ctrl.
//
// Usage:
//   Commands enter on start/opcode/first_object/second_object and are taken
//   at a clock edge where start is high and busy is low. Record, pair query
//   and both searches hold busy while they run; clear, unused opcodes and
//   commands that end at once (endpoint out of range, no objects) leave it low.
//   Results appear on status/object_index for one cycle, marked by done, in
//   the cycle in which busy drops (right after the accepting edge when busy
//   never rose). The receiver cannot stall, so a beat is gone after that.
//   Endpoint checks and searches use n = min(object_count, MAX_OBJECTS).
//   Each search reads one matrix row per cycle from the row memory; that
//   single read port sets the search time.
//   object_count is written through cfg_we/cfg_data; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   Reset clears object_count and the whole matrix through per-row valid
//   bits; a clear command does the same for the matrix.
`default_nettype none

module universal_vertex_finder #(
  parameter int MAX_OBJECTS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [uvf_pkg::CNT_W-1:0]    cfg_data,
  input  wire                          start,
  input  wire  [uvf_pkg::OP_W-1:0]     opcode,
  input  wire  [uvf_pkg::OBJ_W-1:0]    first_object,
  input  wire  [uvf_pkg::OBJ_W-1:0]    second_object,
  output logic                         busy,
  output logic                         done,
  output logic                         status,
  output logic [uvf_pkg::OBJ_W-1:0]    object_index
);

  localparam int AW = $clog2(MAX_OBJECTS);

  logic [uvf_pkg::CNT_W-1:0] object_count;
  logic [uvf_pkg::CNT_W-1:0] live_n;

  uvf_pkg::mem_ctl_t      mem_ctl;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [2*MAX_OBJECTS-1:0] wr_row;
  logic [2*MAX_OBJECTS-1:0] rd_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_count <= '0;
    end else if (cfg_we) begin
      object_count <= cfg_data;
    end
  end

  assign live_n = (int'(object_count) < MAX_OBJECTS) ? object_count
                                                     : uvf_pkg::CNT_W'(MAX_OBJECTS);

  uvf_ctrl #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .live_n        (live_n),
    .start         (start),
    .opcode        (opcode),
    .first_object  (first_object),
    .second_object (second_object),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .object_index  (object_index),
    .mem_ctl       (mem_ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .wr_row        (wr_row),
    .rd_row        (rd_row)
  );

  uvf_row_mem #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_row  (rd_row)
  );

endmodule

`default_nettype wire
